/* src/msc_pkg.sv */
// shared types, constants and tables for the magnetometer scaling and calibration core
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

   typedef enum logic [2:0] {
      OP_MEASURE = 3'd0,
      OP_START   = 3'd1,
      OP_POS     = 3'd2,
      OP_NEG     = 3'd3,
      OP_FINISH  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_NEXT,
      S_PUSH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam int DIV_W = 40;
   localparam int DVS_W = 24;
   localparam int CNT_W = 6;

   localparam int unsigned EXPECT_XY = 190240;
   localparam int unsigned EXPECT_Z  = 177120;

   localparam logic [15:0] GAIN_ONE = 16'd16384;
   localparam logic [15:0] GAIN_MAX = 16'hFFFF;

   localparam logic signed [17:0] TOT_MAX = 18'sd131071;
   localparam logic signed [17:0] TOT_MIN = -18'sd131072;
   localparam logic signed [15:0] SAT_LIMIT = -16'sd4096;

   localparam logic [DIV_W-1:0] FIELD_POS_MAX = 40'd524287;
   localparam logic [DIV_W-1:0] FIELD_NEG_MAX = 40'd524288;

   // counts per gauss for each gain code
   function automatic logic [10:0] scale_of(input logic [2:0] code);
      logic [10:0] s;
      case (code)
         3'd0: s = 11'd1280;
         3'd1: s = 11'd1024;
         3'd2: s = 11'd768;
         3'd3: s = 11'd614;
         3'd4: s = 11'd415;
         3'd5: s = 11'd361;
         3'd6: s = 11'd307;
         default: s = 11'd219;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

/* src/msc_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module msc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [msc_pkg::DIV_W-1:0]   dividend,
   input  wire logic [msc_pkg::DVS_W-1:0]   divisor,
   output msc_pkg::div_stat_type            stat,
   output logic      [msc_pkg::DIV_W-1:0]   quotient
);

   logic [msc_pkg::DIV_W-1:0] dvd_ff;
   logic [msc_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [msc_pkg::DVS_W-1:0] dvs_ff;
   logic [msc_pkg::CNT_W-1:0] cnt_ff;
   logic                      busy_ff, done_ff;
   logic [msc_pkg::DVS_W:0]   rem_sh, diff;
   logic                      ge;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[msc_pkg::DIV_W-1]};
      diff   = rem_sh - {1'b0, dvs_ff};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? diff[msc_pkg::DVS_W-1:0] : rem_sh[msc_pkg::DVS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= msc_pkg::CNT_W'(msc_pkg::DIV_W);
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            // quotient bits shift in where dividend bits leave
            dvd_ff <= {dvd_ff[msc_pkg::DIV_W-2:0], ge};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == msc_pkg::CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

/* src/magnetometer_selftest_calibrate_scale_core.sv */
// top level: field scaling and bias self-test gain calibration
//
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: six sample bytes, tuser: operation
// rsp     | out | rsp_tvalid/rsp_tready | tdata: x,y,z fields, tuser: status flags
// csr     | in  | csr_valid/csr_ready   | csr_data: gain code
//
// measure and successful finish run the shared serial divider once per axis; an axis with
// a zero total on finish skips its division.
// other operations skip the divider.
// one transaction is worked on at a time; the next is taken once the result is queued.
// a stalled result holds in the output register; reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none
module magnetometer_selftest_calibrate_scale_core #(
   parameter int CAL_SAMPLES = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_high_byte, x_low_byte, z_high_byte, z_low_byte, y_high_byte, y_low_byte
   input  wire logic [47:0] req_tdata,
   // operation
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // field_x, field_y, field_z, zero padding
   output logic [63:0]      rsp_tdata,
   // gains_applied, calibration_failed
   output logic [1:0]       rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_data
);

   localparam logic [msc_pkg::DIV_W-1:0] NUM_XY =
      msc_pkg::DIV_W'(64'(msc_pkg::EXPECT_XY) * 64'(CAL_SAMPLES) * 64'd16384);
   localparam logic [msc_pkg::DIV_W-1:0] NUM_Z =
      msc_pkg::DIV_W'(64'(msc_pkg::EXPECT_Z) * 64'(CAL_SAMPLES) * 64'd16384);

   msc_pkg::state_type state_ff, state_in;
   msc_pkg::op_type    op_ff, req_op;
   logic [1:0]         axis_ff;
   logic [2:0]         code_ff;
   logic signed [15:0] raw_ff [3];
   logic signed [17:0] tot_ff [3];
   logic [15:0]        gain_ff [3];
   logic [19:0]        field_ff [3];
   logic               cal_ff, fail_ff;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_data_ff;
   logic [1:0]         rsp_user_ff;

   logic signed [15:0] req_raw [3];
   logic signed [15:0] cur_raw;
   logic signed [17:0] cur_tot;
   logic [16:0]        raw_mag;
   logic [17:0]        tot_mag;
   logic [15:0]        gmul;
   logic [32:0]        prod;
   logic [23:0]        tot_dvs;
   logic [msc_pkg::DIV_W-1:0] dvd;
   logic [msc_pkg::DVS_W-1:0] dvs;
   logic               div_start;
   msc_pkg::div_stat_type div_stat;
   logic [msc_pkg::DIV_W-1:0] quot;
   logic               accept, push;

   assign req_raw[0] = {req_tdata[7:0],   req_tdata[15:8]};
   assign req_raw[1] = {req_tdata[39:32], req_tdata[47:40]};
   assign req_raw[2] = {req_tdata[23:16], req_tdata[31:24]};
   assign req_op     = msc_pkg::op_type'(req_tuser);

   assign req_tready = (state_ff == msc_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign push       = (state_ff == msc_pkg::S_PUSH) && (!rsp_valid_ff || rsp_tready);

   // operands for the current axis
   always_comb begin
      cur_raw = raw_ff[axis_ff];
      cur_tot = tot_ff[axis_ff];
      raw_mag = cur_raw[15] ? 17'(-{cur_raw[15], cur_raw}) : 17'({cur_raw[15], cur_raw});
      tot_mag = cur_tot[17] ? 18'(-cur_tot) : 18'(cur_tot);
      gmul    = cal_ff ? gain_ff[axis_ff] : msc_pkg::GAIN_ONE;
      prod    = raw_mag * gmul;
      tot_dvs = 24'(tot_mag) * 24'd100;
      if (op_ff == msc_pkg::OP_MEASURE) begin
         // raw*4096*g/(scale*16384) reduces to raw*g/(4*scale)
         dvd = msc_pkg::DIV_W'(prod);
         dvs = msc_pkg::DVS_W'({msc_pkg::scale_of(code_ff), 2'b00});
      end else begin
         dvd = (axis_ff == 2'd2) ? NUM_Z : NUM_XY;
         dvs = tot_dvs;
      end
      div_start = (state_ff == msc_pkg::S_MUL) &&
                  !(op_ff == msc_pkg::OP_FINISH && cur_tot == 18'sd0);
   end

   msc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .stat     (div_stat),
      .quotient (quot)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msc_pkg::S_IDLE: begin
            if (accept) begin
               if (req_op == msc_pkg::OP_MEASURE ||
                   (req_op == msc_pkg::OP_FINISH && !fail_ff))
                  state_in = msc_pkg::S_MUL;
               else
                  state_in = msc_pkg::S_PUSH;
            end
         end
         msc_pkg::S_MUL:  state_in = div_start ? msc_pkg::S_DIV : msc_pkg::S_NEXT;
         msc_pkg::S_DIV:  if (div_stat.done) state_in = msc_pkg::S_NEXT;
         msc_pkg::S_NEXT: state_in = (axis_ff == 2'd2) ? msc_pkg::S_PUSH : msc_pkg::S_MUL;
         msc_pkg::S_PUSH: if (push) state_in = msc_pkg::S_IDLE;
         default:         state_in = msc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= msc_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      logic signed [18:0] sum;
      logic               bad;
      if (reset) begin
         code_ff      <= 3'd2;
         cal_ff       <= 1'b0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= 2'd0;
         op_ff        <= msc_pkg::OP_MEASURE;
         for (int i = 0; i < 3; i++) begin
            tot_ff[i]  <= '0;
            gain_ff[i] <= msc_pkg::GAIN_ONE;
         end
      end else begin
         if (csr_valid && csr_ready) code_ff <= csr_data;

         if (accept) begin
            op_ff   <= req_op;
            axis_ff <= 2'd0;
            for (int i = 0; i < 3; i++) begin
               raw_ff[i]   <= req_raw[i];
               field_ff[i] <= '0;
            end
            bad = 1'b0;
            case (req_op)
               msc_pkg::OP_START: begin
                  for (int i = 0; i < 3; i++) tot_ff[i] <= '0;
                  fail_ff <= 1'b0;
               end
               msc_pkg::OP_POS, msc_pkg::OP_NEG: begin
                  if (!fail_ff) begin
                     for (int i = 0; i < 3; i++) begin
                        if (req_op == msc_pkg::OP_POS)
                           sum = 19'(tot_ff[i]) + 19'(req_raw[i]);
                        else
                           sum = 19'(tot_ff[i]) - 19'(req_raw[i]);
                        if (sum > 19'(msc_pkg::TOT_MAX))      tot_ff[i] <= msc_pkg::TOT_MAX;
                        else if (sum < 19'(msc_pkg::TOT_MIN)) tot_ff[i] <= msc_pkg::TOT_MIN;
                        else                                  tot_ff[i] <= sum[17:0];
                        if (req_raw[i] <= msc_pkg::SAT_LIMIT) bad = 1'b1;
                     end
                     if (bad) fail_ff <= 1'b1;
                  end
               end
               msc_pkg::OP_FINISH: begin
                  if (fail_ff) begin
                     for (int i = 0; i < 3; i++) gain_ff[i] <= msc_pkg::GAIN_ONE;
                     cal_ff <= 1'b0;
                  end else begin
                     cal_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end

         // zero total on finish: gain saturates without a division
         if (state_ff == msc_pkg::S_MUL && !div_start)
            gain_ff[axis_ff] <= msc_pkg::GAIN_MAX;

         if (state_ff == msc_pkg::S_DIV && div_stat.done) begin
            if (op_ff == msc_pkg::OP_MEASURE) begin
               if (cur_raw[15])
                  field_ff[axis_ff] <= (quot > msc_pkg::FIELD_NEG_MAX) ? 20'h80000
                                                                       : 20'(-quot[19:0]);
               else
                  field_ff[axis_ff] <= (quot > msc_pkg::FIELD_POS_MAX) ? 20'h7FFFF
                                                                       : quot[19:0];
            end else begin
               gain_ff[axis_ff] <= (quot > msc_pkg::DIV_W'(msc_pkg::GAIN_MAX)) ?
                                   msc_pkg::GAIN_MAX : quot[15:0];
            end
         end

         if (state_ff == msc_pkg::S_NEXT && axis_ff != 2'd2)
            axis_ff <= axis_ff + 2'd1;

         if (push) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {4'd0, field_ff[2], field_ff[1], field_ff[0]};
            rsp_user_ff  <= {fail_ff, cal_ff};
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   a_cal_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(cal_ff) |-> $past(accept && req_tuser == msc_pkg::OP_FINISH))
      else $error("calibrated flag set outside finish");
   a_unity_when_uncal: assert property (@(posedge clock) disable iff (reset)
      !cal_ff |-> (gain_ff[0] == msc_pkg::GAIN_ONE && gain_ff[1] == msc_pkg::GAIN_ONE &&
                   gain_ff[2] == msc_pkg::GAIN_ONE))
      else $error("gains not unity while uncalibrated");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == msc_pkg::S_DIV)
      else $error("division finished outside divide state");
`endif

endmodule
`default_nettype wire

/* bench/tb_magnetometer_selftest_calibrate_scale_core.sv */
// testbench for the magnetometer field scaling and bias self-test calibration core
`timescale 1ns / 1ps
`default_nettype none
module tb_magnetometer_selftest_calibrate_scale_core;

   localparam int CAL_N = 10;
   localparam int LAT = 160;

   typedef struct {
      msc_pkg::op_type op;
      logic [47:0]     bytes;
   } sample_item;

   typedef struct {
      logic [19:0] fx;
      logic [19:0] fy;
      logic [19:0] fz;
      logic        applied;
      logic        failed;
   } field_result;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_data = '0;

   magnetometer_selftest_calibrate_scale_core #(.CAL_SAMPLES(CAL_N)) dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor state
   logic [2:0] range_code;
   longint     bias_sum [3];
   longint     gain_q14 [3];
   bit         cal_failed;
   bit         cal_applied;
   field_result expected_fields [$];
   int         error_count = 0;
   bit         no_idle = 1'b0;
   bit         hold_rsp = 1'b0;

   function automatic longint raw_of(logic [7:0] hi, logic [7:0] lo);
      return longint'($signed({hi, lo}));
   endfunction

   function automatic longint clamp_total(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic longint gain_for(int axis, longint total);
      longint unsigned mag, q, ex;
      if (total == 0) return 65535;
      ex = (axis == 2) ? msc_pkg::EXPECT_Z : msc_pkg::EXPECT_XY;
      mag = (total < 0) ? -total : total;
      q = (ex * CAL_N * 16384) / (100 * mag);
      return (q > 65535) ? 65535 : q;
   endfunction

   function automatic logic [19:0] field_of(longint raw, int axis);
      longint unsigned mag, num, den, q;
      longint s;
      mag = (raw < 0) ? -raw : raw;
      num = mag * 4096;
      case (range_code)
         3'd0: den = 1280;
         3'd1: den = 1024;
         3'd2: den = 768;
         3'd3: den = 614;
         3'd4: den = 415;
         3'd5: den = 361;
         3'd6: den = 307;
         default: den = 219;
      endcase
      if (cal_applied) begin
         num = num * gain_q14[axis];
         den = den * 16384;
      end
      q = num / den;
      if (raw < 0) s = (q > 524288) ? -524288 : -longint'(q);
      else s = (q > 524287) ? 524287 : longint'(q);
      return s[19:0];
   endfunction

   function automatic field_result predict_fields(sample_item it);
      field_result r;
      longint raw [3];
      raw[0] = raw_of(it.bytes[7:0], it.bytes[15:8]);
      raw[2] = raw_of(it.bytes[23:16], it.bytes[31:24]);
      raw[1] = raw_of(it.bytes[39:32], it.bytes[47:40]);
      r.fx = '0; r.fy = '0; r.fz = '0;
      case (it.op)
         msc_pkg::OP_MEASURE: begin
            r.fx = field_of(raw[0], 0);
            r.fy = field_of(raw[1], 1);
            r.fz = field_of(raw[2], 2);
         end
         msc_pkg::OP_START: begin
            foreach (bias_sum[a]) bias_sum[a] = 0;
            cal_failed = 1'b0;
         end
         msc_pkg::OP_POS, msc_pkg::OP_NEG: begin
            if (!cal_failed) begin
               foreach (bias_sum[a])
                  bias_sum[a] = clamp_total(bias_sum[a] +
                                ((it.op == msc_pkg::OP_POS) ? raw[a] : -raw[a]));
               if (raw[0] <= -4096 || raw[1] <= -4096 || raw[2] <= -4096) cal_failed = 1'b1;
            end
         end
         msc_pkg::OP_FINISH: begin
            foreach (gain_q14[a]) gain_q14[a] = cal_failed ? 16384 : gain_for(a, bias_sum[a]);
            cal_applied = !cal_failed;
         end
         default: ;
      endcase
      r.applied = cal_applied;
      r.failed = cal_failed;
      return r;
   endfunction

   // x, z, y raw samples packed high byte first per axis, first byte lowest
   function automatic logic [47:0] pack_raw(logic [15:0] x, logic [15:0] z, logic [15:0] y);
      return {y[7:0], y[15:8], z[7:0], z[15:8], x[7:0], x[15:8]};
   endfunction

   // valid stays up between transactions unless an idle burst drops it
   task automatic send_item(sample_item it);
      while (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      expected_fields.push_back(predict_fields(it));
      req_tvalid <= 1'b1;
      req_tdata <= it.bytes;
      req_tuser <= it.op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_range(logic [2:0] code);
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (expected_fields.size() != 0 && n < 200000) begin
         @(negedge clock);
         n++;
      end
      repeat (LAT) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= code;
      do @(posedge clock); while (!csr_ready);
      range_code = code;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // receiver side with random stalls
   initial begin
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (2000) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      field_result e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_fields.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            error_count++;
         end else begin
            e = expected_fields.pop_front();
            if (rsp_tdata[19:0] !== e.fx) begin
               $error("field_x expected %0d got %0d", $signed(e.fx), $signed(rsp_tdata[19:0]));
               error_count++;
            end
            if (rsp_tdata[39:20] !== e.fy) begin
               $error("field_y expected %0d got %0d", $signed(e.fy), $signed(rsp_tdata[39:20]));
               error_count++;
            end
            if (rsp_tdata[59:40] !== e.fz) begin
               $error("field_z expected %0d got %0d", $signed(e.fz), $signed(rsp_tdata[59:40]));
               error_count++;
            end
            if (rsp_tuser[0] !== e.applied) begin
               $error("gains_applied expected %0b got %0b", e.applied, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[1] !== e.failed) begin
               $error("calibration_failed expected %0b got %0b", e.failed, rsp_tuser[1]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #20000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   typedef struct {
      msc_pkg::op_type op;
      logic [15:0]     x, z, y;
      bit              typed;
      logic [19:0]     fx, fy, fz;
      logic [1:0]      flags;
   } directed_row;

   directed_row rows [] = '{
      // after reset: gain code 2, scale 768, no gains
      '{msc_pkg::OP_MEASURE, 16'h0000, 16'h0000, 16'h0000, 1, 20'd0, 20'd0, 20'd0, 2'b00},
      '{msc_pkg::OP_MEASURE, 16'd768, 16'hFD00, 16'd384, 1,
        20'd4096, 20'd2048, -20'sd4096, 2'b00},
      '{msc_pkg::OP_MEASURE, 16'h7FFF, 16'h8000, 16'hFFFF, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_FINISH, 16'h1234, 16'h5678, 16'h9ABC, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_MEASURE, 16'd1000, 16'hF000, 16'd50, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 20'd0, 20'd0, 20'd0, 2'b01},
      '{msc_pkg::OP_POS, 16'd950, 16'd890, 16'd950, 1, 20'd0, 20'd0, 20'd0, 2'b01},
      '{msc_pkg::OP_NEG, 16'hFC4A, 16'hFC86, 16'hFC4A, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_MEASURE, 16'd2000, 16'd2000, 16'd2000, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_FINISH, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_MEASURE, 16'h7FFF, 16'h8000, 16'd3000, 0, 0, 0, 0, 0},
      // saturated sample then ignored samples, failed finish
      '{msc_pkg::OP_START, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_POS, 16'hF000, 16'd10, 16'd10, 1, 20'd0, 20'd0, 20'd0, 2'b11},
      '{msc_pkg::OP_NEG, 16'd500, 16'd500, 16'd500, 1, 20'd0, 20'd0, 20'd0, 2'b11},
      '{msc_pkg::OP_FINISH, 16'd0, 16'd0, 16'd0, 1, 20'd0, 20'd0, 20'd0, 2'b10},
      // zero total and total overflow
      '{msc_pkg::OP_START, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_POS, 16'h7FFF, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_POS, 16'h7FFF, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_POS, 16'h7FFF, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_POS, 16'h7FFF, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_POS, 16'h7FFF, 16'h0000, 16'h7FFF, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_FINISH, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0},
      '{msc_pkg::OP_MEASURE, 16'h8000, 16'h7FFF, 16'h8001, 0, 0, 0, 0, 0},
      '{msc_pkg::op_type'(3'd5), 16'h1111, 16'h2222, 16'h3333, 0, 0, 0, 0, 0},
      '{msc_pkg::op_type'(3'd7), 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0}
   };

   function automatic logic [15:0] random_raw(bit wide);
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'hF000 - 16'($urandom_range(0, 8));
         default: return wide ? 16'($urandom) : 16'($urandom_range(0, 1400) - 200);
      endcase
   endfunction

   initial begin
      sample_item it;
      field_result e;
      int k, w;
      int cfg_mark;
      bit pressed;
      range_code = 3'd2;
      foreach (bias_sum[a]) begin
         bias_sum[a] = 0;
         gain_q14[a] = 16384;
      end
      cal_failed = 1'b0;
      cal_applied = 1'b0;
      cfg_mark = 0;
      pressed = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         it.op = rows[i].op;
         it.bytes = pack_raw(rows[i].x, rows[i].z, rows[i].y);
         send_item(it);
         if (rows[i].typed && expected_fields.size() != 0) begin
            // the prediction just queued for this row
            e = expected_fields[$];
            if (e.fx !== rows[i].fx || e.fy !== rows[i].fy || e.fz !== rows[i].fz
                || {e.failed, e.applied} !== rows[i].flags) begin
               $error("directed row %0d does not match its typed result", i);
               error_count++;
            end
         end
      end

      // random calibrations and measurements over random gain codes, including codes 0 and 7
      for (k = 0; k < 400;) begin
         if (k >= cfg_mark) begin
            write_range((cfg_mark / 50 == 0) ? 3'd0 :
                        (cfg_mark / 50 == 7) ? 3'd7 : 3'($urandom_range(0, 7)));
            cfg_mark += 50;
         end
         if (k >= 200 && !pressed) begin
            hold_rsp = 1'b1;
            pressed = 1'b1;
         end
         if (k >= 340) no_idle = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            it.op = msc_pkg::OP_START;
            it.bytes = 48'($urandom) << $urandom_range(0, 16);
            send_item(it); k++;
            for (w = $urandom_range(1, 12); w > 0; w--) begin
               it.op = $urandom_range(0, 3) ? msc_pkg::OP_POS : msc_pkg::OP_NEG;
               it.bytes = pack_raw(random_raw(0), random_raw(0), random_raw(0));
               send_item(it); k++;
            end
            it.op = msc_pkg::OP_FINISH; it.bytes = {$urandom, 16'($urandom)};
            send_item(it); k++;
         end else begin
            it.op = ($urandom_range(0, 9) == 0) ? msc_pkg::op_type'($urandom_range(0, 7))
                                                : msc_pkg::OP_MEASURE;
            it.bytes = pack_raw(random_raw(1), random_raw(1), random_raw(1));
            send_item(it); k++;
         end
      end
      req_tvalid <= 1'b0;

      k = 0;
      while (expected_fields.size() != 0 && k < 500000) begin
         @(negedge clock);
         k++;
      end
      repeat (LAT) @(negedge clock);
      if (error_count == 0 && expected_fields.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
